// ----- rtl/ddcm_pkg.sv -----
// Shared types, constants and helper functions of the drive command mixer.
`timescale 1ns / 1ps
package ddcm_pkg;

  localparam int MSG_BYTES_DEF = 12;
  localparam int QDEPTH        = 2;
  localparam int PAT_LEN       = 9;
  localparam int PAT_W         = $clog2(PAT_LEN + 1);

  localparam logic [7:0] PAT_TEXT [PAT_LEN] = '{
    8'h45, 8'h4D, 8'h45, 8'h52, 8'h47, 8'h45, 8'h4E, 8'h43, 8'h59
  };
  localparam logic [PAT_W-1:0] PAT_FAIL [PAT_LEN] = '{
    PAT_W'(0), PAT_W'(0), PAT_W'(0), PAT_W'(1), PAT_W'(0),
    PAT_W'(0), PAT_W'(1), PAT_W'(0), PAT_W'(0)
  };

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic signed [15:0] ACC_MAX = 16'sd32767;
  localparam logic [7:0]         SPEED_MAX = 8'd255;

  localparam logic [7:0] FWD_DB_RST = 8'd50;
  localparam logic [7:0] TRN_DB_RST = 8'd50;
  localparam logic [8:0] LIMIT_RST  = 9'd30;

  localparam logic [1:0] REG_FWD_DB = 2'd0;
  localparam logic [1:0] REG_TRN_DB = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef enum logic [1:0] {
    PH_WAIT_EQ = 2'd0,
    PH_SIGN    = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic              found;
    logic signed [15:0] fwd;
    logic signed [15:0] trn;
    logic [8:0]        sonar;
  } msg_rec_t;

  typedef struct packed {
    logic [7:0] fwd_db;
    logic [7:0] trn_db;
    logic [8:0] limit;
  } cfg_t;

  function automatic logic [PAT_W-1:0] pat_step(input logic [PAT_W-1:0] p,
                                                input logic [7:0] c);
    logic [PAT_W-1:0] q;
    begin
      q = PAT_FAIL[p];
      if (c == PAT_TEXT[p]) begin
        pat_step = p + PAT_W'(1);
      end else if (p != '0 && q == PAT_W'(1) && c == PAT_TEXT[1]) begin
        pat_step = PAT_W'(2);
      end else if (c == PAT_TEXT[0]) begin
        pat_step = PAT_W'(1);
      end else begin
        pat_step = '0;
      end
    end
  endfunction

  function automatic logic signed [15:0] add_digit(input logic signed [15:0] acc,
                                                   input logic [3:0] d,
                                                   input logic neg);
    logic signed [20:0] a;
    logic signed [20:0] v;
    logic signed [20:0] dd;
    begin
      a  = 21'(acc);
      dd = $signed({17'b0, d});
      v  = (a <<< 3) + (a <<< 1);
      v  = neg ? (v - dd) : (v + dd);
      if (v > 21'sd32767) begin
        add_digit = ACC_MAX;
      end else if (v < -21'sd32767) begin
        add_digit = -ACC_MAX;
      end else begin
        add_digit = v[15:0];
      end
    end
  endfunction

  function automatic logic [7:0] drive_mag(input logic signed [16:0] v);
    logic [16:0] m;
    begin
      m = v[16] ? 17'(-v) : 17'(v);
      drive_mag = (m > 17'(SPEED_MAX)) ? SPEED_MAX : m[7:0];
    end
  endfunction

endpackage

// ----- rtl/ddcm_front.sv -----
// Front end: byte parser, pattern watcher and message record builder.
`timescale 1ns / 1ps
module ddcm_front #(
  parameter int MSG_BYTES = ddcm_pkg::MSG_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  logic [7:0]         byte_in,
  input  logic               last_in,
  input  logic [8:0]         sonar_in,
  output logic               push,
  output ddcm_pkg::msg_rec_t rec
);

  localparam int CW = $clog2(MSG_BYTES + 1);
  localparam int PW = ddcm_pkg::PAT_W;

  logic [1:0]              fi_r, fi_nxt;
  ddcm_pkg::phase_t        ph_r, ph_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [15:0]      facc_r, facc_nxt;
  logic signed [15:0]      tacc_r, tacc_nxt;
  logic [PW-1:0]           pm_r, pm_nxt;
  logic                    found_r, found_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [PW-1:0]           pstep;
  logic signed [15:0]      acc_sel, acc_new;
  logic                    is_digit, is_space;

  assign is_digit = (byte_in >= ddcm_pkg::CH_ZERO) && (byte_in <= ddcm_pkg::CH_NINE);
  assign is_space = (byte_in == ddcm_pkg::CH_SPACE) ||
                    ((byte_in >= ddcm_pkg::CH_TAB) && (byte_in <= ddcm_pkg::CH_CR));
  assign pstep    = ddcm_pkg::pat_step(pm_r, byte_in);
  assign acc_sel  = (fi_r == 2'd0) ? facc_r : tacc_r;
  assign acc_new  = ddcm_pkg::add_digit(acc_sel, 4'(byte_in - ddcm_pkg::CH_ZERO), neg_r);

  always_comb begin
    fi_nxt    = fi_r;
    ph_nxt    = ph_r;
    neg_nxt   = neg_r;
    facc_nxt  = facc_r;
    tacc_nxt  = tacc_r;
    pm_nxt    = pm_r;
    found_nxt = found_r;
    cnt_nxt   = cnt_r;
    if (acc && cnt_r < CW'(MSG_BYTES)) begin
      cnt_nxt = cnt_r + CW'(1);
      if (pstep >= PW'(ddcm_pkg::PAT_LEN)) begin
        found_nxt = 1'b1;
        pm_nxt    = '0;
      end else begin
        pm_nxt = pstep;
      end
      if (byte_in == ddcm_pkg::CH_SEMI) begin
        if (fi_r < 2'd2) begin
          fi_nxt = fi_r + 2'd1;
        end
        ph_nxt  = ddcm_pkg::PH_WAIT_EQ;
        neg_nxt = 1'b0;
      end else if (fi_r < 2'd2) begin
        unique case (ph_r)
          ddcm_pkg::PH_WAIT_EQ: begin
            if (byte_in == ddcm_pkg::CH_EQ) begin
              ph_nxt = ddcm_pkg::PH_SIGN;
            end
          end
          ddcm_pkg::PH_SIGN: begin
            priority if (is_space) begin
              ph_nxt = ph_r;
            end else if (byte_in == ddcm_pkg::CH_MINUS || byte_in == ddcm_pkg::CH_PLUS) begin
              neg_nxt = (byte_in == ddcm_pkg::CH_MINUS);
              ph_nxt  = ddcm_pkg::PH_DIGITS;
            end else if (is_digit) begin
              ph_nxt = ddcm_pkg::PH_DIGITS;
              if (fi_r == 2'd0) begin
                facc_nxt = acc_new;
              end else begin
                tacc_nxt = acc_new;
              end
            end else begin
              ph_nxt = ddcm_pkg::PH_DONE;
            end
          end
          ddcm_pkg::PH_DIGITS: begin
            if (is_digit) begin
              if (fi_r == 2'd0) begin
                facc_nxt = acc_new;
              end else begin
                tacc_nxt = acc_new;
              end
            end else begin
              ph_nxt = ddcm_pkg::PH_DONE;
            end
          end
          default: begin
            ph_nxt = ph_r;
          end
        endcase
      end
    end
  end

  assign push      = acc && last_in;
  assign rec.found = found_nxt;
  assign rec.fwd   = facc_nxt;
  assign rec.trn   = tacc_nxt;
  assign rec.sonar = sonar_in;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      fi_r    <= 2'd0;
      ph_r    <= ddcm_pkg::PH_WAIT_EQ;
      neg_r   <= 1'b0;
      facc_r  <= '0;
      tacc_r  <= '0;
      pm_r    <= '0;
      found_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      fi_r    <= fi_nxt;
      ph_r    <= ph_nxt;
      neg_r   <= neg_nxt;
      facc_r  <= facc_nxt;
      tacc_r  <= tacc_nxt;
      pm_r    <= pm_nxt;
      found_r <= found_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/ddcm_queue.sv -----
// Short queue of message records between the front and back ends.
`timescale 1ns / 1ps
module ddcm_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ddcm_pkg::msg_rec_t rec_in,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output ddcm_pkg::msg_rec_t rec_out
);

  localparam int AW = $clog2(ddcm_pkg::QDEPTH);
  localparam int NW = $clog2(ddcm_pkg::QDEPTH + 1);

  ddcm_pkg::msg_rec_t mem_r [ddcm_pkg::QDEPTH];
  logic [AW-1:0]      wp_r, wp_nxt;
  logic [AW-1:0]      rp_r, rp_nxt;
  logic [NW-1:0]      n_r, n_nxt;

  assign full    = (n_r == NW'(ddcm_pkg::QDEPTH));
  assign valid   = (n_r != '0);
  assign rec_out = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + AW'(1) : wp_r;
    rp_nxt = pop  ? rp_r + AW'(1) : rp_r;
    n_nxt  = n_r + NW'(push) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      n_r  <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= rec_in;
    end
  end

endmodule

// ----- rtl/ddcm_back.sv -----
// Back end: deadband, arcade mixing, obstacle stop and output register.
`timescale 1ns / 1ps
module ddcm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ddcm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  ddcm_pkg::msg_rec_t q_rec,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               emergency,
  output logic               motors_updated,
  output logic [7:0]         left_speed,
  output logic               left_forward,
  output logic [7:0]         right_speed,
  output logic               right_forward,
  output logic               obstacle_stop
);

  logic               vld_r, vld_nxt;
  logic               mf_r, mf_nxt;
  logic               emg_r, upd_r, lfw_r, rfw_r, stp_r;
  logic [7:0]         lsp_r, rsp_r;
  logic               emg_nxt, upd_nxt, lfw_nxt, rfw_nxt, stp_nxt;
  logic [7:0]         lsp_nxt, rsp_nxt;
  logic [15:0]        fa, ta;
  logic signed [15:0] fz, tz;
  logic signed [16:0] lv, rv;
  logic               mf_mix, mf_eff, near;

  assign q_pop = q_valid && (!vld_r || out_ready);

  always_comb begin
    fa     = q_rec.fwd[15] ? 16'(-q_rec.fwd) : 16'(q_rec.fwd);
    ta     = q_rec.trn[15] ? 16'(-q_rec.trn) : 16'(q_rec.trn);
    fz     = (fa < {8'b0, cfg.fwd_db}) ? 16'sd0 : q_rec.fwd;
    tz     = (ta < {8'b0, cfg.trn_db}) ? 16'sd0 : q_rec.trn;
    lv     = 17'(fz) - 17'(tz);
    rv     = 17'(fz) + 17'(tz);
    mf_mix = (lv > 17'sd0) && (rv > 17'sd0);
    mf_eff = q_rec.found ? mf_r : mf_mix;
    near   = (q_rec.sonar != 9'd0) && (q_rec.sonar <= cfg.limit);

    emg_nxt = q_rec.found;
    upd_nxt = !q_rec.found;
    lsp_nxt = q_rec.found ? 8'd0 : ddcm_pkg::drive_mag(lv);
    rsp_nxt = q_rec.found ? 8'd0 : ddcm_pkg::drive_mag(rv);
    lfw_nxt = !q_rec.found && !lv[16];
    rfw_nxt = !q_rec.found && !rv[16];
    stp_nxt = 1'b0;
    if (mf_eff && near) begin
      lsp_nxt = 8'd0;
      rsp_nxt = 8'd0;
      lfw_nxt = 1'b1;
      rfw_nxt = 1'b1;
      upd_nxt = 1'b1;
      stp_nxt = 1'b1;
    end

    vld_nxt = q_pop ? 1'b1 : (out_ready ? 1'b0 : vld_r);
    mf_nxt  = q_pop ? mf_eff : mf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      mf_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      mf_r  <= mf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      emg_r <= emg_nxt;
      upd_r <= upd_nxt;
      lsp_r <= lsp_nxt;
      lfw_r <= lfw_nxt;
      rsp_r <= rsp_nxt;
      rfw_r <= rfw_nxt;
      stp_r <= stp_nxt;
    end
  end

  assign out_valid      = vld_r;
  assign emergency      = emg_r;
  assign motors_updated = upd_r;
  assign left_speed     = lsp_r;
  assign left_forward   = lfw_r;
  assign right_speed    = rsp_r;
  assign right_forward  = rfw_r;
  assign obstacle_stop  = stp_r;

  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && stp_r |-> lsp_r == 8'd0 && rsp_r == 8'd0 && upd_r && lfw_r && rfw_r)
    else $error("obstacle stop with motors running");

  a_plain_updates: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !emg_r |-> upd_r)
    else $error("non-emergency word without motor update");

  a_idle_motors: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !upd_r |-> lsp_r == 8'd0 && rsp_r == 8'd0 && !lfw_r && !rfw_r)
    else $error("motor fields set without update");

  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> vld_r)
    else $error("popped record not presented");

endmodule

// ----- rtl/differential_drive_command_mixer.sv -----
// Top level of the differential drive command mixer.
//
// Input stream: one message byte per word; in_tdata holds the byte and the
// sonar distance, in_tlast marks the final byte of a message. The sonar
// distance is used only with the final byte.
// Output stream: one word per message, issued after its final byte, with
// the emergency flag, the update flag, both motor speeds and directions and
// the obstacle stop flag.
// Throughput: one byte per cycle while in_tready is high. The result word
// passes from the record queue through the mixer into the output register.
// A two-entry record queue sits between the byte parser and the mixer, so
// bytes keep flowing while a result waits; in_tready falls only once the
// queue is full behind a stalled output.
// Reset clears the parser, the queue, the output valid flag and the forward
// flag, and loads the register defaults (deadbands 50, obstacle limit 30).
// Write the cfg_ registers only while no message is in flight.
`timescale 1ns / 1ps
module differential_drive_command_mixer #(
  parameter int MSG_BYTES = ddcm_pkg::MSG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // message_byte[7:0], sonar_distance_cm[16:8], zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // emergency[0], motors_updated[1], left_speed[9:2],
                                  // left_forward[10], right_speed[18:11],
                                  // right_forward[19], obstacle_stop[20], zero
);

  ddcm_pkg::cfg_t     cfg_r, cfg_nxt;
  ddcm_pkg::msg_rec_t f_rec, q_rec;
  logic               in_acc, push, q_full, q_valid, q_pop;
  logic               emg, upd, lfw, rfw, stp;
  logic [7:0]         lsp, rsp;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        ddcm_pkg::REG_FWD_DB: cfg_nxt.fwd_db = cfg_wdata[7:0];
        ddcm_pkg::REG_TRN_DB: cfg_nxt.trn_db = cfg_wdata[7:0];
        ddcm_pkg::REG_LIMIT:  cfg_nxt.limit  = cfg_wdata;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fwd_db <= ddcm_pkg::FWD_DB_RST;
      cfg_r.trn_db <= ddcm_pkg::TRN_DB_RST;
      cfg_r.limit  <= ddcm_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  ddcm_front #(
    .MSG_BYTES(MSG_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .byte_in  (in_tdata[7:0]),
    .last_in  (in_tlast),
    .sonar_in (in_tdata[16:8]),
    .push     (push),
    .rec      (f_rec)
  );

  ddcm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .rec_in  (f_rec),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rec_out (q_rec)
  );

  ddcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .q_valid        (q_valid),
    .q_rec          (q_rec),
    .q_pop          (q_pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .emergency      (emg),
    .motors_updated (upd),
    .left_speed     (lsp),
    .left_forward   (lfw),
    .right_speed    (rsp),
    .right_forward  (rfw),
    .obstacle_stop  (stp)
  );

  assign out_tdata = {3'b0, stp, rfw, rsp, lfw, lsp, upd, emg};

endmodule
